FILE: sv/tbtpd_pkg.sv
// ----------------------------------------------------------------------------
// tbtpd_pkg
// Shared widths, phase codes, register map, reset values and reciprocal
// constants for the two-burst tone pattern detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tbtpd_pkg;

    // Data path widths
    localparam int SAMPLE_WIDTH = 24;
    localparam int COUNT_WIDTH  = 18;
    localparam int PHASE_WIDTH  = 3;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 5;
    localparam int REG_IDX_W    = 3;

    // Quotient widths: x/2, x/5, x/100, x/126 of a SAMPLE_WIDTH value
    localparam int Q2_W   = SAMPLE_WIDTH - 1;
    localparam int Q5_W   = SAMPLE_WIDTH - 2;
    localparam int Q100_W = SAMPLE_WIDTH - 6;
    localparam int Q126_W = SAMPLE_WIDTH - 6;

    // Phase codes
    localparam logic [PHASE_WIDTH-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_FIRST   = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_GAP     = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_SECOND  = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] PH_CONFIRM = 3'd4;
    localparam logic [PHASE_WIDTH-1:0] PH_NOISE   = 3'd5;
    localparam logic [PHASE_WIDTH-1:0] PH_SETTLE  = 3'd6;

    // Register map (word index)
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CEILING   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_LEN = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GAP_LEN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_LEN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CONFIRM_LEN = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_HOLDOFF_LEN = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SETTLE_LEN = 3'd7;

    // Reset values
    localparam logic [SAMPLE_WIDTH-1:0] RST_THRESHOLD   = SAMPLE_WIDTH'(4000);
    localparam logic [SAMPLE_WIDTH-1:0] RST_CEILING     = '1;
    localparam logic [COUNT_WIDTH-1:0]  RST_FIRST_LEN   = COUNT_WIDTH'(2600);
    localparam logic [COUNT_WIDTH-1:0]  RST_GAP_LEN     = COUNT_WIDTH'(9000);
    localparam logic [COUNT_WIDTH-1:0]  RST_SECOND_LEN  = COUNT_WIDTH'(10000);
    localparam logic [COUNT_WIDTH-1:0]  RST_CONFIRM_LEN = COUNT_WIDTH'(250);
    localparam logic [COUNT_WIDTH-1:0]  RST_HOLDOFF_LEN = COUNT_WIDTH'(150000);
    localparam logic [COUNT_WIDTH-1:0]  RST_SETTLE_LEN  = COUNT_WIDTH'(50000);

    // Ratio test divisors
    localparam int DIV_UPPER_2 = 2;
    localparam int DIV_UPPER_5 = 5;
    localparam int DIV_LOWER_100 = 100;
    localparam int DIV_LOWER_126 = 126;

    // Reciprocal multiply: x/d = (x * ceil(2^s/d)) >> s, s = width + clog2(d)
    localparam int MULT_W    = SAMPLE_WIDTH + 1;
    localparam int PROD_W    = SAMPLE_WIDTH + MULT_W;
    localparam int SHIFT5    = SAMPLE_WIDTH + $clog2(DIV_UPPER_5);
    localparam int SHIFT100  = SAMPLE_WIDTH + $clog2(DIV_LOWER_100);
    localparam int SHIFT126  = SAMPLE_WIDTH + $clog2(DIV_LOWER_126);

    typedef logic [MULT_W-1:0] recip_t;

    localparam recip_t RECIP5 =
        recip_t'(((64'd1 << SHIFT5) + 64'(DIV_UPPER_5 - 1)) / 64'(DIV_UPPER_5));
    localparam recip_t RECIP100 =
        recip_t'(((64'd1 << SHIFT100) + 64'(DIV_LOWER_100 - 1)) / 64'(DIV_LOWER_100));
    localparam recip_t RECIP126 =
        recip_t'(((64'd1 << SHIFT126) + 64'(DIV_LOWER_126 - 1)) / 64'(DIV_LOWER_126));

    // Configuration register set
    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] threshold;
        logic [SAMPLE_WIDTH-1:0] ceiling;
        logic [COUNT_WIDTH-1:0]  first_len;
        logic [COUNT_WIDTH-1:0]  gap_len;
        logic [COUNT_WIDTH-1:0]  second_len;
        logic [COUNT_WIDTH-1:0]  confirm_len;
        logic [COUNT_WIDTH-1:0]  holdoff_len;
        logic [COUNT_WIDTH-1:0]  settle_len;
    } cfg_t;

    // Sample with its precomputed quotients
    typedef struct packed {
        logic                    valid;
        logic                    mode;
        logic [SAMPLE_WIDTH-1:0] mag;
        logic [Q2_W-1:0]         q2;
        logic [Q5_W-1:0]         q5;
        logic [Q100_W-1:0]       q100;
        logic [Q126_W-1:0]       q126;
    } samp_t;

endpackage

`default_nettype wire

FILE: sv/two_burst_tone_pattern_detector.sv
// A result is registered in the input, quotient and sequencer stages in turn.
// Throughput: one transaction per cycle while the result is not stalled;
//   phase update: compares and a counter increment; quotients a stage earlier.
// Reset (aresetn low, synchronous): settle phase, count and peaks cleared,
//   registers back to their defaults, pipeline emptied.
// ----------------------------------------------------------------------------
// two_burst_tone_pattern_detector
// Top level: APB register file, input stage, quotient stage and the phase
// sequencer for the two-tone chime detector.
// ----------------------------------------------------------------------------
`default_nettype none

module two_burst_tone_pattern_detector (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Sample channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_mode,
    input  wire logic [tbtpd_pkg::SAMPLE_WIDTH-1:0] s_magnitude,
    // Result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_detect,
    output logic [tbtpd_pkg::PHASE_WIDTH-1:0]       m_phase,
    output logic [tbtpd_pkg::SAMPLE_WIDTH-1:0]      m_first_peak,
    output logic [tbtpd_pkg::SAMPLE_WIDTH-1:0]      m_second_peak,
    // Configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tbtpd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [tbtpd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tbtpd_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                    pready
);
    import tbtpd_pkg::*;

    cfg_t                    cfg_reg;
    logic                    cfg_wr;
    logic [REG_IDX_W-1:0]    reg_idx;
    logic                    adv;
    logic                    in_valid_reg;
    logic                    in_mode_reg;
    logic [SAMPLE_WIDTH-1:0] in_mag_reg;
    samp_t                   samp;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold   <= RST_THRESHOLD;
            cfg_reg.ceiling     <= RST_CEILING;
            cfg_reg.first_len   <= RST_FIRST_LEN;
            cfg_reg.gap_len     <= RST_GAP_LEN;
            cfg_reg.second_len  <= RST_SECOND_LEN;
            cfg_reg.confirm_len <= RST_CONFIRM_LEN;
            cfg_reg.holdoff_len <= RST_HOLDOFF_LEN;
            cfg_reg.settle_len  <= RST_SETTLE_LEN;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_THRESHOLD:   cfg_reg.threshold   <= pwdata[SAMPLE_WIDTH-1:0];
                REG_CEILING:     cfg_reg.ceiling     <= pwdata[SAMPLE_WIDTH-1:0];
                REG_FIRST_LEN:   cfg_reg.first_len   <= pwdata[COUNT_WIDTH-1:0];
                REG_GAP_LEN:     cfg_reg.gap_len     <= pwdata[COUNT_WIDTH-1:0];
                REG_SECOND_LEN:  cfg_reg.second_len  <= pwdata[COUNT_WIDTH-1:0];
                REG_CONFIRM_LEN: cfg_reg.confirm_len <= pwdata[COUNT_WIDTH-1:0];
                REG_HOLDOFF_LEN: cfg_reg.holdoff_len <= pwdata[COUNT_WIDTH-1:0];
                REG_SETTLE_LEN:  cfg_reg.settle_len  <= pwdata[COUNT_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register reads
    always_comb begin
        case (reg_idx)
            REG_THRESHOLD:   prdata = APB_DATA_W'(cfg_reg.threshold);
            REG_CEILING:     prdata = APB_DATA_W'(cfg_reg.ceiling);
            REG_FIRST_LEN:   prdata = APB_DATA_W'(cfg_reg.first_len);
            REG_GAP_LEN:     prdata = APB_DATA_W'(cfg_reg.gap_len);
            REG_SECOND_LEN:  prdata = APB_DATA_W'(cfg_reg.second_len);
            REG_CONFIRM_LEN: prdata = APB_DATA_W'(cfg_reg.confirm_len);
            REG_HOLDOFF_LEN: prdata = APB_DATA_W'(cfg_reg.holdoff_len);
            REG_SETTLE_LEN:  prdata = APB_DATA_W'(cfg_reg.settle_len);
            default:         prdata = '0;
        endcase
    end

    // Advance the whole pipeline when the result slot is free or drained
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
        if (adv) begin
            in_mode_reg <= s_mode;
            in_mag_reg  <= s_magnitude;
        end
    end

    tbtpd_quot u_quot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (in_valid_reg),
        .in_mode  (in_mode_reg),
        .in_mag   (in_mag_reg),
        .samp     (samp)
    );

    tbtpd_fsm u_fsm (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .adv             (adv),
        .samp            (samp),
        .cfg             (cfg_reg),
        .out_valid       (m_valid),
        .out_detect      (m_detect),
        .out_phase       (m_phase),
        .out_first_peak  (m_first_peak),
        .out_second_peak (m_second_peak)
    );

endmodule

`default_nettype wire

FILE: sv/tbtpd_quot.sv
// ----------------------------------------------------------------------------
// tbtpd_quot
// Quotient stage: divides the registered magnitude by the ratio-test
// constants with reciprocal multiplies (a shift for 2) and registers the results.
// ----------------------------------------------------------------------------
`default_nettype none

module tbtpd_quot (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              adv,
    input  wire logic                              in_valid,
    input  wire logic                              in_mode,
    input  wire logic [tbtpd_pkg::SAMPLE_WIDTH-1:0] in_mag,
    output tbtpd_pkg::samp_t                       samp
);
    import tbtpd_pkg::*;

    logic [PROD_W-1:0] prod5;
    logic [PROD_W-1:0] prod100;
    logic [PROD_W-1:0] prod126;
    samp_t             samp_reg;
    samp_t             samp_next;

    // Multiply by the scaled reciprocals
    assign prod5   = PROD_W'(in_mag) * PROD_W'(RECIP5);
    assign prod100 = PROD_W'(in_mag) * PROD_W'(RECIP100);
    assign prod126 = PROD_W'(in_mag) * PROD_W'(RECIP126);

    // Assemble the next stage contents
    always_comb begin
        samp_next       = samp_reg;
        samp_next.valid = in_valid;
        samp_next.mode  = in_mode;
        samp_next.mag   = in_mag;
        samp_next.q2    = in_mag[SAMPLE_WIDTH-1:1];
        samp_next.q5    = prod5[SHIFT5 +: Q5_W];
        samp_next.q100  = prod100[SHIFT100 +: Q100_W];
        samp_next.q126  = prod126[SHIFT126 +: Q126_W];
    end

    // Advance with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samp_reg.valid <= 1'b0;
        end else if (adv) begin
            samp_reg.valid <= samp_next.valid;
        end
        if (adv) begin
            samp_reg.mode <= samp_next.mode;
            samp_reg.mag  <= samp_next.mag;
            samp_reg.q2   <= samp_next.q2;
            samp_reg.q5   <= samp_next.q5;
            samp_reg.q100 <= samp_next.q100;
            samp_reg.q126 <= samp_next.q126;
        end
    end

    assign samp = samp_reg;

endmodule

`default_nettype wire

FILE: sv/tbtpd_fsm.sv
// ----------------------------------------------------------------------------
// tbtpd_fsm
// Phase sequencer: window counter, peak tracking and the peak ratio test.
// The phase and peak registers double as the held result.
// ----------------------------------------------------------------------------
`default_nettype none

module tbtpd_fsm (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               adv,
    input  wire tbtpd_pkg::samp_t                   samp,
    input  wire tbtpd_pkg::cfg_t                    cfg,
    output logic                                    out_valid,
    output logic                                    out_detect,
    output logic [tbtpd_pkg::PHASE_WIDTH-1:0]       out_phase,
    output logic [tbtpd_pkg::SAMPLE_WIDTH-1:0]      out_first_peak,
    output logic [tbtpd_pkg::SAMPLE_WIDTH-1:0]      out_second_peak
);
    import tbtpd_pkg::*;

    logic                    take;
    logic [PHASE_WIDTH-1:0]  ph_reg, ph_next;
    logic [COUNT_WIDTH-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic [SAMPLE_WIDTH-1:0] fp_reg, fp_next;
    logic [Q2_W-1:0]         fp_q2_reg, fp_q2_next;
    logic [Q100_W-1:0]       fp_q100_reg, fp_q100_next;
    logic [SAMPLE_WIDTH-1:0] sp_reg, sp_next;
    logic [Q5_W-1:0]         sp_q5_reg, sp_q5_next;
    logic [Q126_W-1:0]       sp_q126_reg, sp_q126_next;
    logic                    det_next;
    logic                    det_reg;
    logic                    valid_reg;
    logic                    ratio_ok;

    assign take    = adv && samp.valid;
    assign cnt_inc = cnt_reg + COUNT_WIDTH'(1);

    // Peak ratio test on the stored quotients
    assign ratio_ok = (Q2_W'(sp_q5_reg) <= fp_q2_reg) && (sp_q126_reg >= fp_q100_reg);

    // Next phase, count and peaks
    always_comb begin
        ph_next      = ph_reg;
        cnt_next     = cnt_reg;
        fp_next      = fp_reg;
        fp_q2_next   = fp_q2_reg;
        fp_q100_next = fp_q100_reg;
        sp_next      = sp_reg;
        sp_q5_next   = sp_q5_reg;
        sp_q126_next = sp_q126_reg;
        det_next     = 1'b0;
        if (samp.mode) begin
            ph_next  = PH_SETTLE;
            cnt_next = '0;
        end else begin
            case (ph_reg)
                PH_IDLE: begin
                    fp_next      = '0;
                    fp_q2_next   = '0;
                    fp_q100_next = '0;
                    sp_next      = '0;
                    sp_q5_next   = '0;
                    sp_q126_next = '0;
                    if (samp.mag > cfg.ceiling) begin
                        ph_next  = PH_NOISE;
                        cnt_next = '0;
                    end else if (samp.mag > cfg.threshold) begin
                        fp_next      = samp.mag;
                        fp_q2_next   = samp.q2;
                        fp_q100_next = samp.q100;
                        ph_next      = PH_FIRST;
                        cnt_next     = '0;
                    end
                end
                PH_FIRST: begin
                    if (samp.mag > cfg.ceiling) begin
                        ph_next  = PH_NOISE;
                        cnt_next = '0;
                    end else begin
                        if (samp.mag > fp_reg) begin
                            fp_next      = samp.mag;
                            fp_q2_next   = samp.q2;
                            fp_q100_next = samp.q100;
                        end
                        cnt_next = cnt_inc;
                        if (cnt_inc >= cfg.first_len) begin
                            ph_next  = PH_GAP;
                            cnt_next = '0;
                        end
                    end
                end
                PH_GAP: begin
                    if (samp.mag > fp_reg) begin
                        ph_next  = PH_NOISE;
                        cnt_next = '0;
                    end else if (cnt_reg < cfg.gap_len) begin
                        cnt_next = cnt_inc;
                    end else begin
                        ph_next  = PH_SECOND;
                        cnt_next = '0;
                    end
                end
                PH_SECOND: begin
                    if (cnt_reg < cfg.second_len) begin
                        cnt_next = cnt_inc;
                        if (samp.mag > sp_reg) begin
                            sp_next      = samp.mag;
                            sp_q5_next   = samp.q5;
                            sp_q126_next = samp.q126;
                        end
                    end else begin
                        ph_next  = ratio_ok ? PH_CONFIRM : PH_NOISE;
                        cnt_next = '0;
                    end
                end
                PH_CONFIRM: begin
                    if (cnt_reg < cfg.confirm_len) begin
                        cnt_next = cnt_inc;
                    end else begin
                        det_next = 1'b1;
                        ph_next  = PH_SETTLE;
                        cnt_next = '0;
                    end
                end
                PH_NOISE: begin
                    if (cnt_reg < cfg.holdoff_len) begin
                        cnt_next = cnt_inc;
                    end else begin
                        ph_next  = PH_IDLE;
                        cnt_next = '0;
                    end
                end
                PH_SETTLE: begin
                    if (cnt_reg < cfg.settle_len) begin
                        cnt_next = cnt_inc;
                    end else begin
                        ph_next  = PH_IDLE;
                        cnt_next = '0;
                    end
                end
                default: begin
                    ph_next  = PH_SETTLE;
                    cnt_next = '0;
                end
            endcase
        end
    end

    // Update state and the result slot on each consumed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg      <= PH_SETTLE;
            cnt_reg     <= '0;
            fp_reg      <= '0;
            fp_q2_reg   <= '0;
            fp_q100_reg <= '0;
            sp_reg      <= '0;
            sp_q5_reg   <= '0;
            sp_q126_reg <= '0;
            det_reg     <= 1'b0;
            valid_reg   <= 1'b0;
        end else begin
            if (adv) begin
                valid_reg <= samp.valid;
            end
            if (take) begin
                ph_reg      <= ph_next;
                cnt_reg     <= cnt_next;
                fp_reg      <= fp_next;
                fp_q2_reg   <= fp_q2_next;
                fp_q100_reg <= fp_q100_next;
                sp_reg      <= sp_next;
                sp_q5_reg   <= sp_q5_next;
                sp_q126_reg <= sp_q126_next;
                det_reg     <= det_next;
            end
        end
    end

    assign out_valid       = valid_reg;
    assign out_detect      = det_reg;
    assign out_phase       = ph_reg;
    assign out_first_peak  = fp_reg;
    assign out_second_peak = sp_reg;

`ifndef SYNTHESIS
    // A detect pulse always lands in the settle phase
    a_detect_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        det_reg |-> (ph_reg == PH_SETTLE))
        else $error("detect raised outside settle phase");

    // Reset brings the sequencer to settle
    a_reset_settle: assert property (@(posedge aclk)
        !aresetn |=> (ph_reg == PH_SETTLE) && (cnt_reg == '0))
        else $error("reset did not return to settle");

    // Idle always runs with a cleared window count
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ph_reg == PH_IDLE) |-> (cnt_reg == '0))
        else $error("window count nonzero in idle");

    // The gap phase is only reached with a first peak above zero
    a_gap_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        (ph_reg == PH_GAP) |-> (fp_reg != '0))
        else $error("gap phase with empty first peak");

    // State holds while no sample is consumed
    a_hold_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !take |=> $stable(ph_reg) && $stable(cnt_reg))
        else $error("state changed without a consumed sample");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-burst tone pattern detector. A software
// copy of the phase sequencer predicts every result transaction; the bench
// drives short chimes, noise and restarts under several register settings,
// with random gaps on the sample side and random back-pressure on the
// result side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tbtpd_pkg::*;

    localparam int unsigned MAG_MAX     = 2**SAMPLE_WIDTH - 1;
    localparam int unsigned LEN_MAX     = 2**COUNT_WIDTH - 1;
    localparam int unsigned BURST_LIMIT = 6000000;
    localparam int          DRAIN_CYCLES = 6;

    typedef struct packed {
        logic                    detect;
        logic [PHASE_WIDTH-1:0]  phase;
        logic [SAMPLE_WIDTH-1:0] first_peak;
        logic [SAMPLE_WIDTH-1:0] second_peak;
    } report_t;

    // Clock, reset and block ports
    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_mode = 1'b0;
    logic [SAMPLE_WIDTH-1:0] s_magnitude = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_detect;
    logic [PHASE_WIDTH-1:0]  m_phase;
    logic [SAMPLE_WIDTH-1:0] m_first_peak;
    logic [SAMPLE_WIDTH-1:0] m_second_peak;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // Tracked detector state and register copy
    cfg_t                    trk_cfg;
    logic [PHASE_WIDTH-1:0]  trk_phase;
    logic [COUNT_WIDTH-1:0]  trk_count;
    logic [SAMPLE_WIDTH-1:0] trk_first_peak;
    logic [SAMPLE_WIDTH-1:0] trk_second_peak;

    report_t     due_reports[$];
    int unsigned mismatches = 0;
    bit          quiet_run = 1'b0;
    int unsigned stall_left = 0;

    two_burst_tone_pattern_detector uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pause_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_run || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void enter_phase(input logic [PHASE_WIDTH-1:0] ph);
        trk_phase = ph;
        trk_count = '0;
    endfunction

    // Advance the tracked sequencer by one sample and return the report
    function automatic report_t phase_step(input logic mode,
                                           input logic [SAMPLE_WIDTH-1:0] mag);
        report_t rep;
        logic    ratio_ok;
        rep.detect = 1'b0;
        if (mode) begin
            enter_phase(PH_SETTLE);
        end else begin
            case (trk_phase)
                PH_IDLE: begin
                    trk_first_peak = '0;
                    trk_second_peak = '0;
                    if (mag > trk_cfg.ceiling) begin
                        enter_phase(PH_NOISE);
                    end else if (mag > trk_cfg.threshold) begin
                        trk_first_peak = mag;
                        enter_phase(PH_FIRST);
                    end
                end
                PH_FIRST: begin
                    if (mag > trk_cfg.ceiling) begin
                        enter_phase(PH_NOISE);
                    end else begin
                        if (mag > trk_first_peak) trk_first_peak = mag;
                        trk_count = trk_count + 1'b1;
                        if (trk_count >= trk_cfg.first_len) enter_phase(PH_GAP);
                    end
                end
                PH_GAP: begin
                    if (mag > trk_first_peak) begin
                        enter_phase(PH_NOISE);
                    end else if (trk_count < trk_cfg.gap_len) begin
                        trk_count = trk_count + 1'b1;
                    end else begin
                        enter_phase(PH_SECOND);
                    end
                end
                PH_SECOND: begin
                    if (trk_count < trk_cfg.second_len) begin
                        trk_count = trk_count + 1'b1;
                        if (mag > trk_second_peak) trk_second_peak = mag;
                    end else begin
                        ratio_ok = (trk_second_peak / DIV_UPPER_5
                                        <= trk_first_peak / DIV_UPPER_2)
                                && (trk_second_peak / DIV_LOWER_126
                                        >= trk_first_peak / DIV_LOWER_100);
                        enter_phase(ratio_ok ? PH_CONFIRM : PH_NOISE);
                    end
                end
                PH_CONFIRM: begin
                    if (trk_count < trk_cfg.confirm_len) begin
                        trk_count = trk_count + 1'b1;
                    end else begin
                        rep.detect = 1'b1;
                        enter_phase(PH_SETTLE);
                    end
                end
                PH_NOISE: begin
                    if (trk_count < trk_cfg.holdoff_len) trk_count = trk_count + 1'b1;
                    else enter_phase(PH_IDLE);
                end
                PH_SETTLE: begin
                    if (trk_count < trk_cfg.settle_len) trk_count = trk_count + 1'b1;
                    else enter_phase(PH_IDLE);
                end
                default: begin
                    enter_phase(PH_SETTLE);
                end
            endcase
        end
        rep.phase = trk_phase;
        rep.first_peak = trk_first_peak;
        rep.second_peak = trk_second_peak;
        return rep;
    endfunction

    // Pick a magnitude that mostly keeps a chime going from the current phase
    function automatic logic [SAMPLE_WIDTH-1:0] choose_magnitude();
        int unsigned thr, ceil_v, fpk, lim, lo, hi, r;
        thr = trk_cfg.threshold;
        ceil_v = trk_cfg.ceiling;
        fpk = trk_first_peak;
        lim = (ceil_v > BURST_LIMIT) ? BURST_LIMIT : ceil_v;
        r = $urandom_range(0, 15);
        case (trk_phase)
            PH_IDLE: begin
                if (thr >= lim) return SAMPLE_WIDTH'($urandom_range(MAG_MAX, 0));
                if (r < 4) return SAMPLE_WIDTH'($urandom_range(thr, 0));
                return SAMPLE_WIDTH'($urandom_range(lim, thr + 1));
            end
            PH_FIRST: begin
                if (r == 0) return SAMPLE_WIDTH'(ceil_v);
                if (r == 1 && ceil_v < MAG_MAX) return SAMPLE_WIDTH'(ceil_v + 1);
                return SAMPLE_WIDTH'($urandom_range(lim, 0));
            end
            PH_GAP: begin
                if (r == 0) return SAMPLE_WIDTH'(fpk);
                if (r == 1 && fpk < MAG_MAX) return SAMPLE_WIDTH'(fpk + 1);
                return SAMPLE_WIDTH'($urandom_range(fpk, 0));
            end
            PH_SECOND: begin
                // aim inside the ratio window, sometimes right on or past an edge
                lo = DIV_LOWER_126 * (fpk / DIV_LOWER_100);
                hi = DIV_UPPER_5 * (fpk / DIV_UPPER_2) + DIV_UPPER_5 - 1;
                if (lo > MAG_MAX) lo = MAG_MAX;
                if (hi > MAG_MAX) hi = MAG_MAX;
                if (r == 0) return SAMPLE_WIDTH'(lo);
                if (r == 1) return SAMPLE_WIDTH'(hi);
                if (r == 2 && lo > 0) return SAMPLE_WIDTH'(lo - 1);
                if (r == 3 && hi < MAG_MAX) return SAMPLE_WIDTH'(hi + 1);
                return SAMPLE_WIDTH'($urandom_range(hi, lo));
            end
            default: begin
                return SAMPLE_WIDTH'($urandom_range(MAG_MAX, 0));
            end
        endcase
    endfunction

    // One register write: setup and access phases, then the bus goes idle
    task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_THRESHOLD:   trk_cfg.threshold = value[SAMPLE_WIDTH-1:0];
            REG_CEILING:     trk_cfg.ceiling = value[SAMPLE_WIDTH-1:0];
            REG_FIRST_LEN:   trk_cfg.first_len = value[COUNT_WIDTH-1:0];
            REG_GAP_LEN:     trk_cfg.gap_len = value[COUNT_WIDTH-1:0];
            REG_SECOND_LEN:  trk_cfg.second_len = value[COUNT_WIDTH-1:0];
            REG_CONFIRM_LEN: trk_cfg.confirm_len = value[COUNT_WIDTH-1:0];
            REG_HOLDOFF_LEN: trk_cfg.holdoff_len = value[COUNT_WIDTH-1:0];
            REG_SETTLE_LEN:  trk_cfg.settle_len = value[COUNT_WIDTH-1:0];
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic load_settings(input cfg_t c);
        write_register(REG_THRESHOLD, APB_DATA_W'(c.threshold));
        write_register(REG_CEILING, APB_DATA_W'(c.ceiling));
        write_register(REG_FIRST_LEN, APB_DATA_W'(c.first_len));
        write_register(REG_GAP_LEN, APB_DATA_W'(c.gap_len));
        write_register(REG_SECOND_LEN, APB_DATA_W'(c.second_len));
        write_register(REG_CONFIRM_LEN, APB_DATA_W'(c.confirm_len));
        write_register(REG_HOLDOFF_LEN, APB_DATA_W'(c.holdoff_len));
        write_register(REG_SETTLE_LEN, APB_DATA_W'(c.settle_len));
    endtask

    // Offer one sample, wait for the transaction, record its report
    task automatic send_sample(input logic mode, input logic [SAMPLE_WIDTH-1:0] mag);
        int unsigned gap;
        s_valid <= 1'b1;
        s_mode <= mode;
        s_magnitude <= mag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        due_reports.push_back(phase_step(mode, mag));
        gap = pause_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid, wait for every report, then let the pipeline empty
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (due_reports.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly chime-shaped samples, some raw noise and a few restarts
    task automatic run_traffic(input int unsigned count);
        int unsigned r;
        for (int unsigned i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2) send_sample(1'b1, SAMPLE_WIDTH'($urandom_range(MAG_MAX, 0)));
            else if (r < 14) send_sample(1'b0, SAMPLE_WIDTH'($urandom_range(MAG_MAX, 0)));
            else send_sample(1'b0, choose_magnitude());
        end
    endtask

    // Default registers: restart and settle counting at both magnitude extremes
    task automatic test_reset_state();
        send_sample(1'b1, SAMPLE_WIDTH'(MAG_MAX));
        send_sample(1'b0, SAMPLE_WIDTH'(MAG_MAX));
        send_sample(1'b0, '0);
        wait_idle();
    endtask

    // Full chime through every phase but noise, up to the detect pulse
    task automatic test_directed_chime();
        load_settings('{threshold: SAMPLE_WIDTH'(1000), ceiling: SAMPLE_WIDTH'(50000),
                        first_len: COUNT_WIDTH'(2), gap_len: COUNT_WIDTH'(1),
                        second_len: COUNT_WIDTH'(1), confirm_len: COUNT_WIDTH'(1),
                        holdoff_len: COUNT_WIDTH'(2), settle_len: '0});
        send_sample(1'b0, '0);
        send_sample(1'b0, SAMPLE_WIDTH'(500));
        send_sample(1'b0, SAMPLE_WIDTH'(2000));
        send_sample(1'b0, SAMPLE_WIDTH'(4000));
        send_sample(1'b0, SAMPLE_WIDTH'(3000));
        send_sample(1'b0, SAMPLE_WIDTH'(100));
        send_sample(1'b0, SAMPLE_WIDTH'(4000));
        send_sample(1'b0, SAMPLE_WIDTH'(9000));
        send_sample(1'b0, '0);
        send_sample(1'b0, '0);
        send_sample(1'b0, '0);
        send_sample(1'b0, '0);
        wait_idle();
    endtask

    // Ceiling noise, hold-off, gap louder than the first peak, restart
    task automatic test_noise_paths();
        send_sample(1'b0, SAMPLE_WIDTH'(60000));
        send_sample(1'b0, '0);
        send_sample(1'b0, '0);
        send_sample(1'b0, '0);
        send_sample(1'b0, SAMPLE_WIDTH'(2000));
        send_sample(1'b0, SAMPLE_WIDTH'(50000));
        send_sample(1'b0, SAMPLE_WIDTH'(3000));
        send_sample(1'b0, SAMPLE_WIDTH'(50001));
        send_sample(1'b1, SAMPLE_WIDTH'(MAG_MAX));
        wait_idle();
    endtask

    // Random register settings with short windows so chimes complete
    task automatic test_random_settings();
        cfg_t c;
        for (int p = 0; p < 8; p++) begin
            c.threshold = SAMPLE_WIDTH'($urandom_range(2000000, 0));
            if ($urandom_range(0, 1) != 0) c.ceiling = SAMPLE_WIDTH'(MAG_MAX);
            else c.ceiling = SAMPLE_WIDTH'($urandom_range(MAG_MAX, c.threshold + 1));
            c.first_len = (p == 0) ? '0 : COUNT_WIDTH'($urandom_range(6, 0));
            c.gap_len = COUNT_WIDTH'($urandom_range(6, 0));
            c.second_len = COUNT_WIDTH'($urandom_range(6, 0));
            c.confirm_len = COUNT_WIDTH'($urandom_range(4, 0));
            c.holdoff_len = COUNT_WIDTH'($urandom_range(6, 0));
            c.settle_len = COUNT_WIDTH'($urandom_range(4, 0));
            load_settings(c);
            quiet_run = ($urandom_range(0, 3) == 0);
            run_traffic(220);
            quiet_run = 1'b0;
            wait_idle();
        end
    endtask

    // Register extremes: widest windows, then zero windows with a shut ceiling
    task automatic test_extreme_settings();
        load_settings('{threshold: '0, ceiling: SAMPLE_WIDTH'(MAG_MAX),
                        first_len: COUNT_WIDTH'(LEN_MAX), gap_len: COUNT_WIDTH'(LEN_MAX),
                        second_len: COUNT_WIDTH'(LEN_MAX),
                        confirm_len: COUNT_WIDTH'(LEN_MAX),
                        holdoff_len: COUNT_WIDTH'(LEN_MAX),
                        settle_len: COUNT_WIDTH'(LEN_MAX)});
        run_traffic(24);
        send_sample(1'b1, '0);
        wait_idle();
        load_settings('{threshold: SAMPLE_WIDTH'(MAG_MAX), ceiling: '0, first_len: '0,
                        gap_len: '0, second_len: '0, confirm_len: '0, holdoff_len: '0,
                        settle_len: '0});
        send_sample(1'b0, '0);
        run_traffic(24);
        send_sample(1'b0, '0);
        wait_idle();
    endtask

    // Result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pause_len();
        end
    end

    // Compare each result transaction with the oldest outstanding report
    always @(posedge aclk) begin : check_reports
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_reports.size() == 0) begin
                $error("result transaction with no report outstanding");
                mismatches++;
            end else begin
                want = due_reports.pop_front();
                if (m_detect !== want.detect) begin
                    $error("detect: expected %0d, got %0d", want.detect, m_detect);
                    mismatches++;
                end
                if (m_phase !== want.phase) begin
                    $error("phase: expected %0d, got %0d", want.phase, m_phase);
                    mismatches++;
                end
                if (m_first_peak !== want.first_peak) begin
                    $error("first_peak: expected %0d, got %0d",
                           want.first_peak, m_first_peak);
                    mismatches++;
                end
                if (m_second_peak !== want.second_peak) begin
                    $error("second_peak: expected %0d, got %0d",
                           want.second_peak, m_second_peak);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        trk_cfg = '{RST_THRESHOLD, RST_CEILING, RST_FIRST_LEN, RST_GAP_LEN,
                    RST_SECOND_LEN, RST_CONFIRM_LEN, RST_HOLDOFF_LEN, RST_SETTLE_LEN};
        trk_phase = PH_SETTLE;
        trk_count = '0;
        trk_first_peak = '0;
        trk_second_peak = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_directed_chime();
        test_noise_paths();
        test_random_settings();
        test_extreme_settings();
        if (mismatches == 0 && due_reports.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
